@@ rtl/core/dmrk4_pkg.sv @@
// Shared types and constants of the dense Markov RK4 step block.
`default_nettype none
package dmrk4_pkg;

  // Input word: one command to the block
  typedef struct packed {
    logic [1:0]          mode;
    logic [3:0]          row_index;
    logic [3:0]          col_index;
    logic signed [31:0]  value;
  } dmrk4_in_t;

  // Output word: step completion or read data
  typedef struct packed {
    logic                result_kind;
    logic [3:0]          state_index;
    logic signed [31:0]  probability;
    logic                sum_not_positive;
  } dmrk4_out_t;

  // Command codes carried in the mode field
  typedef enum logic [1:0] {
    MODE_WR_RATE = 2'd0,
    MODE_WR_PROB = 2'd1,
    MODE_STEP    = 2'd2,
    MODE_READ    = 2'd3
  } dmrk4_mode_t;

  // Result kinds
  localparam logic KIND_STEP = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_STATES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP     = 1'b1;

  // Register reset values
  localparam logic [4:0]  ACTIVE_STATES_RST = 5'd3;
  localparam logic [30:0] TIME_STEP_RST     = 31'd16777;

  // Reciprocal of three, 32 fraction bits, rounded down
  localparam logic [31:0] RECIP3 = 32'h5555_5555;

  // Runge-Kutta slope being evaluated
  typedef enum logic [1:0] {
    PH_K1 = 2'd0,
    PH_K2 = 2'd1,
    PH_K3 = 2'd2,
    PH_K4 = 2'd3
  } dmrk4_phase_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_OUT,
    S_MAC,
    S_DRAIN,
    S_RE_RD,
    S_RE_ACC,
    S_RE_D3,
    S_RE_W6,
    S_RE_MUL,
    S_RE_WR,
    S_NRM_CHK,
    S_NRM_RD,
    S_NRM_LD,
    S_NRM_DIV
  } dmrk4_state_t;

  // Divider status
  typedef struct packed {
    logic busy;
    logic done;
  } dmrk4_div_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/dmrk4_div.sv @@
// Bit-serial restoring divider used by the normalisation pass.
`default_nettype none
module dmrk4_div import dmrk4_pkg::*; #(
  parameter int DEN_W = 35,
  parameter int QB    = 25
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DEN_W+QB-1:0]   num,
  input  wire logic [DEN_W-1:0]      den,
  output logic      [QB-1:0]         quot,
  output dmrk4_div_stat_t            stat
);

  localparam int CNT_W = $clog2(QB + 1);

  logic [DEN_W-1:0] rem_r;
  logic [QB-1:0]    lo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem_r, lo_r[QB-1]};
    diff  = trial - {1'b0, den};
    ge    = (trial >= {1'b0, den});
  end

  // Control: count one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QB);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and quotient share the low register
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[DEN_W+QB-1:QB];
      lo_r  <= num[QB-1:0];
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      lo_r  <= {lo_r[QB-2:0], ge};
    end
  end

  assign quot      = lo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
`default_nettype wire

@@ rtl/core/dense_markov_rk4_step.sv @@
// Top level of the dense Markov RK4 step block.
// Holds an n-by-n rate matrix and a probability vector in on-chip RAMs and
// advances the vector by one fourth-order Runge-Kutta step of dp/dt = R p on
// a step word, then clamps negatives and renormalises by the sum. Values are
// signed fixed point with FRAC_BITS fraction bits and saturate to 32 bits.
// Rate and probability writes return nothing; a read loads the entry in
// S_RD and presents its word from the registered output in S_OUT. A step is
// driven by a single multiply-accumulate unit streaming one matrix entry per
// cycle, and the normalisation pass uses the bit-serial divider. Memories
// hold no reset value; reading an entry never written returns undefined data.
`default_nettype none
module dense_markov_rk4_step import dmrk4_pkg::*; #(
  parameter int MAX_STATES = 16,
  parameter int FRAC_BITS  = 24
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire dmrk4_in_t               in_word,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output dmrk4_out_t                   out_word,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_STATES);
  localparam int RA_W  = $clog2(MAX_STATES * MAX_STATES);
  localparam int SA_W  = IDX_W + 1;
  localparam int ACC_W = 66 - FRAC_BITS + IDX_W;
  localparam int ACN_W = 35;
  localparam int SUM_W = 31 + IDX_W;
  localparam int QB    = FRAC_BITS + 1;
  localparam int NUM_W = SUM_W + QB;

  // Round to nearest, ties away from zero, after a right shift
  function automatic logic signed [65:0] rnd_shr(input logic signed [65:0] v,
                                                 input int unsigned sh);
    logic [65:0] mag;
    logic [65:0] q;
    mag = v[65] ? 66'(-v) : 66'(v);
    q   = (mag + (66'd1 << (sh - 1))) >> sh;
    rnd_shr = v[65] ? -$signed(q) : $signed(q);
  endfunction

  // Saturate to 32 bits signed
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < -66'sd2147483648) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  // Configuration registers
  logic [4:0]  active_states_r;
  logic [30:0] time_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_states_r <= ACTIVE_STATES_RST;
      time_step_r     <= TIME_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACTIVE_STATES: active_states_r <= cfg_wdata[4:0];
        CFG_TIME_STEP:     time_step_r     <= cfg_wdata;
        default:           ;
      endcase
    end
  end

  // Sequencer and datapath registers
  dmrk4_state_t        state_r, state_nxt;
  dmrk4_phase_t        ph_r, ph_nxt;
  logic [IDX_W-1:0]    i_r, i_nxt;
  logic [IDX_W-1:0]    j_r, j_nxt;
  logic [IDX_W-1:0]    nm1_r, nm1_nxt;
  logic                v1_r, v1_nxt;
  logic                v2_r, v2_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [31:0]  y_r, y_nxt;
  logic signed [31:0]  p_r, p_nxt;
  logic signed [ACN_W-1:0] accn_r, accn_nxt;
  logic [34:0]         y2_r, y2_nxt;
  logic                neg_r, neg_nxt;
  logic [66:0]         d3prod_r, d3prod_nxt;
  logic signed [32:0]  w6_r, w6_nxt;
  logic signed [65:0]  prod_r, prod_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic                snp_r, snp_nxt;
  logic                is_read_r, is_read_nxt;
  logic [3:0]          rd_row_r, rd_row_nxt;
  logic                rd_ok_r, rd_ok_nxt;
  logic                out_valid_r, out_valid_nxt;
  dmrk4_out_t          out_word_r, out_word_nxt;

  // Memory ports
  logic                rate_we;
  logic [RA_W-1:0]     rate_waddr, rate_raddr;
  logic signed [31:0]  rate_wdata, rate_q;
  logic                prob_we;
  logic [IDX_W-1:0]    prob_waddr, prob_raddr;
  logic signed [31:0]  prob_wdata, prob_q;
  logic                stage_we;
  logic [SA_W-1:0]     stage_waddr, stage_raddr;
  logic signed [31:0]  stage_wdata, stage_q;
  logic                accum_we;
  logic signed [ACN_W-1:0] accum_q;

  logic signed [31:0]  rate_mem  [0:MAX_STATES*MAX_STATES-1];
  logic signed [31:0]  prob_mem  [0:MAX_STATES-1];
  logic signed [31:0]  stage_mem [0:2*MAX_STATES-1];
  logic signed [ACN_W-1:0] accum_mem [0:MAX_STATES-1];

  // Divider
  logic                div_start;
  logic [NUM_W-1:0]    div_num;
  logic [QB-1:0]       div_quot;
  dmrk4_div_stat_t     div_stat;

  dmrk4_div #(
    .DEN_W (SUM_W),
    .QB    (QB)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (sum_r),
    .quot  (div_quot),
    .stat  (div_stat)
  );

  // Decoded input and helpers
  logic                in_fire;
  logic                row_ok, col_ok;
  logic                last_i, last_j;
  logic [IDX_W-1:0]    n_last;
  logic signed [32:0]  mul_a, mul_b;
  logic signed [65:0]  stage_sum;
  logic signed [31:0]  new_val;
  logic [34:0]         mag35;
  logic [34:0]         q0;
  logic [35:0]         rem3;
  logic [34:0]         qq;

  assign in_fire = in_valid && in_ready;
  assign row_ok  = (32'(in_word.row_index) < 32'(MAX_STATES));
  assign col_ok  = (32'(in_word.col_index) < 32'(MAX_STATES));
  assign last_i  = (i_r == nm1_r);
  assign last_j  = (j_r == nm1_r);

  // Clip the state count to one .. MAX_STATES
  always_comb begin
    if (active_states_r == 5'd0) begin
      n_last = '0;
    end else if (32'(active_states_r) > 32'(MAX_STATES)) begin
      n_last = IDX_W'(MAX_STATES - 1);
    end else begin
      n_last = IDX_W'(active_states_r - 5'd1);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_word.mode)
            MODE_STEP: state_nxt = S_MAC;
            MODE_READ: state_nxt = S_RD;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_RD:      state_nxt = S_OUT;
      S_OUT:     if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      S_MAC:     if (last_j) state_nxt = S_DRAIN;
      S_DRAIN:   if (!v1_r && !v2_r) state_nxt = S_RE_RD;
      S_RE_RD:   state_nxt = S_RE_ACC;
      S_RE_ACC:  state_nxt = (ph_r == PH_K4) ? S_RE_D3 : S_RE_MUL;
      S_RE_D3:   state_nxt = S_RE_W6;
      S_RE_W6:   state_nxt = S_RE_MUL;
      S_RE_MUL:  state_nxt = S_RE_WR;
      S_RE_WR: begin
        if (last_i && ph_r == PH_K4) state_nxt = S_NRM_CHK;
        else                         state_nxt = S_MAC;
      end
      S_NRM_CHK: state_nxt = (sum_r == '0) ? S_OUT : S_NRM_RD;
      S_NRM_RD:  state_nxt = S_NRM_LD;
      S_NRM_LD:  state_nxt = S_NRM_DIV;
      S_NRM_DIV: begin
        if (div_stat.done) state_nxt = last_i ? S_OUT : S_NRM_RD;
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    ph_nxt        = ph_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    nm1_nxt       = nm1_r;
    v1_nxt        = (state_r == S_MAC);
    v2_nxt        = v1_r;
    acc_nxt       = acc_r;
    y_nxt         = y_r;
    p_nxt         = p_r;
    accn_nxt      = accn_r;
    y2_nxt        = y2_r;
    neg_nxt       = neg_r;
    d3prod_nxt    = d3prod_r;
    w6_nxt        = w6_r;
    sum_nxt       = sum_r;
    snp_nxt       = snp_r;
    is_read_nxt   = is_read_r;
    rd_row_nxt    = rd_row_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;

    rate_we     = 1'b0;
    rate_waddr  = RA_W'(32'(in_word.row_index) * MAX_STATES + 32'(in_word.col_index));
    rate_wdata  = in_word.value;
    rate_raddr  = RA_W'(32'(i_r) * MAX_STATES + 32'(j_r));
    prob_we     = 1'b0;
    prob_waddr  = i_r;
    prob_wdata  = in_word.value;
    prob_raddr  = i_r;
    stage_we    = 1'b0;
    stage_waddr = (ph_r == PH_K2) ? SA_W'(MAX_STATES) + SA_W'(i_r) : SA_W'(i_r);
    stage_raddr = (ph_r == PH_K3) ? SA_W'(MAX_STATES) + SA_W'(j_r) : SA_W'(j_r);
    accum_we    = 1'b0;
    div_start   = 1'b0;
    div_num     = (NUM_W'(prob_q[30:0]) << FRAC_BITS) + NUM_W'(sum_r >> 1);

    // Shared multiplier: matrix entry times vector entry, or dt times slope
    mul_a = 33'(rate_q);
    mul_b = (ph_r == PH_K1) ? 33'(prob_q) : 33'(stage_q);
    if (state_r == S_RE_MUL) begin
      mul_a = $signed({2'b00, time_step_r});
      mul_b = (ph_r == PH_K4) ? w6_r : 33'(y_r);
    end
    prod_nxt = mul_a * mul_b;

    // Stage or update value from the rounded dt product
    if (ph_r == PH_K1 || ph_r == PH_K2) begin
      stage_sum = 66'(p_r) + rnd_shr(prod_r, FRAC_BITS + 1);
    end else begin
      stage_sum = 66'(p_r) + rnd_shr(prod_r, FRAC_BITS);
    end
    new_val = sat32(stage_sum);

    // Divide by six: halve with rounding bias, then reciprocal of three
    mag35 = accn_r[ACN_W-1] ? 35'(-accn_r) : 35'(accn_r);
    q0    = d3prod_r[66:32];
    rem3  = 36'(y2_r) - 36'(q0) * 36'd3;
    if (rem3 >= 36'd6)      qq = q0 + 35'd2;
    else if (rem3 >= 36'd3) qq = q0 + 35'd1;
    else                    qq = q0;

    // Drop the output word once taken
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    // Accumulate rounded products as they leave the multiplier
    if (state_r != S_MAC && state_r != S_DRAIN) begin
      acc_nxt = '0;
    end else if (v2_r) begin
      acc_nxt = acc_r + $signed(ACC_W'(rnd_shr(prod_r, FRAC_BITS)));
    end

    case (state_r)
      S_IDLE: begin
        prob_raddr = IDX_W'(in_word.row_index);
        if (in_fire) begin
          case (in_word.mode)
            MODE_WR_RATE: rate_we = row_ok && col_ok;
            MODE_WR_PROB: begin
              prob_we    = row_ok;
              prob_waddr = IDX_W'(in_word.row_index);
            end
            MODE_STEP: begin
              ph_nxt      = PH_K1;
              i_nxt       = '0;
              j_nxt       = '0;
              nm1_nxt     = n_last;
              sum_nxt     = '0;
              is_read_nxt = 1'b0;
            end
            default: begin
              is_read_nxt = 1'b1;
              rd_row_nxt  = in_word.row_index;
              rd_ok_nxt   = row_ok;
            end
          endcase
        end
      end
      S_RD: p_nxt = prob_q;
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (is_read_r) begin
            out_word_nxt.result_kind      = KIND_READ;
            out_word_nxt.state_index      = rd_row_r;
            out_word_nxt.probability      = rd_ok_r ? p_r : 32'sd0;
            out_word_nxt.sum_not_positive = 1'b0;
          end else begin
            out_word_nxt.result_kind      = KIND_STEP;
            out_word_nxt.state_index      = 4'd0;
            out_word_nxt.probability      = 32'sd0;
            out_word_nxt.sum_not_positive = snp_r;
          end
        end
      end
      S_MAC: begin
        prob_raddr = j_r;
        if (!last_j) j_nxt = j_r + 1'b1;
      end
      S_DRAIN: begin
        if (!v1_r && !v2_r) y_nxt = sat32(66'(acc_r));
      end
      S_RE_ACC: begin
        p_nxt = prob_q;
        case (ph_r)
          PH_K1:   accn_nxt = ACN_W'(y_r);
          PH_K4:   accn_nxt = accum_q + ACN_W'(y_r);
          default: accn_nxt = accum_q + ACN_W'(y_r) + ACN_W'(y_r);
        endcase
        accum_we = 1'b1;
      end
      S_RE_D3: begin
        y2_nxt     = 35'((36'(mag35) + 36'd3) >> 1);
        neg_nxt    = accn_r[ACN_W-1];
        d3prod_nxt = 67'(y2_nxt) * 67'(RECIP3);
      end
      S_RE_W6: w6_nxt = neg_r ? -$signed(33'(qq)) : $signed(33'(qq));
      S_RE_WR: begin
        if (ph_r == PH_K4) begin
          // Clamp the updated probability and add it to the sum
          prob_we    = 1'b1;
          prob_wdata = new_val[31] ? 32'sd0 : new_val;
          if (!new_val[31]) sum_nxt = sum_r + SUM_W'(new_val[30:0]);
        end else begin
          stage_we = 1'b1;
        end
        j_nxt = '0;
        if (last_i) begin
          i_nxt = '0;
          if (ph_r != PH_K4) ph_nxt = dmrk4_phase_t'(ph_r + 2'd1);
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      S_NRM_CHK: begin
        snp_nxt = (sum_r == '0);
        i_nxt   = '0;
      end
      S_NRM_LD: div_start = 1'b1;
      S_NRM_DIV: begin
        if (div_stat.done) begin
          prob_we    = 1'b1;
          prob_wdata = 32'(div_quot);
          if (!last_i) i_nxt = i_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign stage_wdata = new_val;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ph_r       <= ph_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    nm1_r      <= nm1_nxt;
    acc_r      <= acc_nxt;
    y_r        <= y_nxt;
    p_r        <= p_nxt;
    accn_r     <= accn_nxt;
    y2_r       <= y2_nxt;
    neg_r      <= neg_nxt;
    d3prod_r   <= d3prod_nxt;
    w6_r       <= w6_nxt;
    prod_r     <= prod_nxt;
    sum_r      <= sum_nxt;
    snp_r      <= snp_nxt;
    is_read_r  <= is_read_nxt;
    rd_row_r   <= rd_row_nxt;
    rd_ok_r    <= rd_ok_nxt;
    out_word_r <= out_word_nxt;
  end

  // Rate matrix RAM
  always_ff @(posedge clk) begin
    if (rate_we) rate_mem[rate_waddr] <= rate_wdata;
    rate_q <= rate_mem[rate_raddr];
  end

  // Probability RAM
  always_ff @(posedge clk) begin
    if (prob_we) prob_mem[prob_waddr] <= prob_wdata;
    prob_q <= prob_mem[prob_raddr];
  end

  // Stage RAM, two banks alternating between slopes
  always_ff @(posedge clk) begin
    if (stage_we) stage_mem[stage_waddr] <= stage_wdata;
    stage_q <= stage_mem[stage_raddr];
  end

  // Weighted slope sum RAM
  always_ff @(posedge clk) begin
    if (accum_we) accum_mem[i_r] <= accn_nxt;
    accum_q <= accum_mem[i_r];
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
`default_nettype wire
